/* rtl/core/sphd_pkg.sv */
package sphd_pkg;

  // Fixed widths of the register and request fields.
  localparam int DECAY_STEP_W = 8;
  localparam int BIN_COUNT_W  = 11;
  localparam int BIN_INDEX_W  = 10;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [DECAY_STEP_W-1:0] DECAY_STEP_RESET = 8'd16;
  localparam logic [BIN_COUNT_W-1:0]  BIN_COUNT_RESET  = 11'd1024;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic {
    REG_DECAY_STEP = 1'b0,
    REG_BIN_COUNT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DECAY_STEP_W-1:0] decay_step;
    logic [BIN_COUNT_W-1:0]  bin_count;
  } cfg_t;

  typedef struct packed {
    logic peak_valid;
    logic decay_changed;
    logic index_error;
  } res_flags_t;

  // Occupancy of the result queue and whether its head leaves this cycle.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } q_stat_t;

endpackage

/* rtl/core/sphd_regs.sv */
module sphd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sphd_pkg::PADDR_W-1:0]   paddr,
  input  logic [sphd_pkg::PDATA_W-1:0]   pwdata,
  output logic [sphd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output sphd_pkg::cfg_t                 cfg
);
  import sphd_pkg::*;

  reg_idx_t reg_sel;
  logic     wr;
  logic     aligned;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign aligned = (paddr[1:0] == 2'b00);
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_step <= DECAY_STEP_RESET;
      cfg.bin_count  <= BIN_COUNT_RESET;
    end else if (wr) begin
      case (reg_sel)
        REG_DECAY_STEP: cfg.decay_step <= pwdata[DECAY_STEP_W-1:0];
        REG_BIN_COUNT:  cfg.bin_count  <= pwdata[BIN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (aligned) begin
      case (reg_sel)
        REG_DECAY_STEP: prdata = PDATA_W'(cfg.decay_step);
        REG_BIN_COUNT:  prdata = PDATA_W'(cfg.bin_count);
        default:        prdata = '0;
      endcase
    end
  end

endmodule

/* rtl/core/sphd_store.sv */
module sphd_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 25
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // A read and a write of the same entry at one edge return the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sphd_outq.sv */
module sphd_outq #(
  parameter int LEVEL_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic signed [LEVEL_BITS-1:0] push_peak,
  input  sphd_pkg::res_flags_t         push_flags,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [LEVEL_BITS-1:0] peak_value,
  output sphd_pkg::res_flags_t         out_flags,
  output sphd_pkg::q_stat_t            q_stat
);
  import sphd_pkg::*;

  logic signed [LEVEL_BITS-1:0] q_peak [2];
  res_flags_t                   q_flags [2];
  logic                         head;
  logic                         tail;
  logic [1:0]                   count;
  logic                         pop;

  assign out_valid    = (count != 2'd0);
  assign pop          = out_valid && !out_stall;
  assign tail         = head ^ count[0];
  assign peak_value   = q_peak[head];
  assign out_flags    = q_flags[head];
  assign q_stat.count = count;
  assign q_stat.pop   = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      head  <= head ^ pop;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_peak[tail]  <= push_peak;
      q_flags[tail] <= push_flags;
    end
  end

endmodule

/* rtl/core/sphd_engine.sv */
module sphd_engine #(
  parameter int MAX_BINS   = 1024,
  parameter int LEVEL_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sphd_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            req_type,
  input  logic [sphd_pkg::BIN_INDEX_W-1:0]      bin_index,
  input  logic signed [LEVEL_BITS-1:0]          bin_value,
  output logic                                  mem_we,
  output logic [$clog2(MAX_BINS)-1:0]           mem_waddr,
  output logic [2*LEVEL_BITS:0]                 mem_wdata,
  output logic                                  mem_re,
  output logic [$clog2(MAX_BINS)-1:0]           mem_raddr,
  input  logic [2*LEVEL_BITS:0]                 mem_rdata,
  input  sphd_pkg::q_stat_t                     q_stat,
  output logic                                  push,
  output logic signed [LEVEL_BITS-1:0]          push_peak,
  output sphd_pkg::res_flags_t                  push_flags
);
  import sphd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_BINS);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int DATA_W = 2 * LEVEL_BITS + 1;
  localparam int EXT_W  = LEVEL_BITS + 2;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);
  localparam logic signed [LEVEL_BITS-1:0] FLOOR = {1'b1, {(LEVEL_BITS-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] FLOOR_EXT = {3'b111, {(LEVEL_BITS-1){1'b0}}};

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_SCAN, ST_CLEAR} state_t;
  typedef enum logic [1:0] {OP_SAMPLE, OP_READ, OP_ERR, OP_SCAN} op_t;

  state_t state;
  op_t    s1_op;
  logic   s1_valid;
  logic [ADDR_W-1:0]            s1_addr;
  logic signed [LEVEL_BITS-1:0] s1_value;
  logic                         lw_valid;
  logic [ADDR_W-1:0]            lw_addr;
  logic [DATA_W-1:0]            lw_data;
  logic [CNT_W-1:0]             scan_idx;
  logic [ADDR_W-1:0]            sweep_addr;
  logic                         changed;

  req_t        req;
  logic [31:0] used32;
  logic [CNT_W-1:0] used;
  logic        in_range;
  logic        is_addr_req;
  logic        accept;
  logic        room;
  logic [2:0]  occ;
  logic        scan_issue;
  logic        sweep_active;
  logic        tick_done;
  logic        clear_done;
  logic        s1_push;
  logic        decay_hit;

  logic [DATA_W-1:0]            word;
  logic                         w_valid;
  logic signed [LEVEL_BITS-1:0] w_peak;
  logic signed [LEVEL_BITS-1:0] w_cur;
  logic signed [LEVEL_BITS-1:0] new_peak;
  logic signed [EXT_W-1:0]      diff;
  logic signed [LEVEL_BITS-1:0] decayed;

  assign req    = req_t'(req_type);
  assign used32 = (32'(cfg.bin_count) > 32'(MAX_BINS)) ? 32'(MAX_BINS) : 32'(cfg.bin_count);
  assign used   = used32[CNT_W-1:0];
  assign in_range    = (32'(bin_index) < used32);
  assign is_addr_req = (req == REQ_SAMPLE) || (req == REQ_READ);

  // Space is counted from the queued results and the one in flight, less the one leaving.
  assign s1_push  = s1_valid && (s1_op != OP_SCAN);
  assign occ      = {1'b0, q_stat.count} + {2'b00, s1_push};
  assign room     = (occ - {2'b00, q_stat.pop}) < 3'd2;
  assign in_stall = !((state == ST_IDLE) && room);
  assign accept   = in_valid && !in_stall;

  assign scan_issue   = (state == ST_SCAN) && (scan_idx != used);
  assign tick_done    = (state == ST_SCAN) && (scan_idx == used) && !s1_valid;
  assign sweep_active = ((state == ST_INIT) || (state == ST_CLEAR)) && !s1_valid;
  assign clear_done   = (state == ST_CLEAR) && sweep_active && (sweep_addr == LAST_ADDR);

  assign mem_re    = (accept && is_addr_req && in_range) || scan_issue;
  assign mem_raddr = scan_issue ? scan_idx[ADDR_W-1:0] : ADDR_W'(bin_index);

  // The word written at the previous edge is newer than what the read returned.
  assign word    = (lw_valid && (lw_addr == s1_addr)) ? lw_data : mem_rdata;
  assign w_valid = word[DATA_W-1];
  assign w_peak  = word[DATA_W-2 -: LEVEL_BITS];
  assign w_cur   = word[LEVEL_BITS-1:0];

  assign new_peak = (!w_valid || (s1_value > w_peak)) ? s1_value : w_peak;
  assign diff     = $signed({{2{w_peak[LEVEL_BITS-1]}}, w_peak})
                  - $signed({{(LEVEL_BITS-6){1'b0}}, cfg.decay_step});
  assign decayed  = (diff < FLOOR_EXT) ? FLOOR : diff[LEVEL_BITS-1:0];
  assign decay_hit = s1_valid && (s1_op == OP_SCAN) && w_valid && (w_peak > w_cur)
                   && (cfg.decay_step != '0) && (decayed != w_peak);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr;
    mem_wdata = {1'b1, new_peak, s1_value};
    if (s1_valid && (s1_op == OP_SAMPLE)) begin
      mem_we = 1'b1;
    end else if (decay_hit) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b1, decayed, w_cur};
    end else if (sweep_active) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end
  end

  always_comb begin
    push       = s1_push || tick_done || clear_done;
    push_peak  = '0;
    push_flags = '0;
    if (s1_push) begin
      if (s1_op == OP_SAMPLE) begin
        push_peak             = new_peak;
        push_flags.peak_valid = 1'b1;
      end else if (s1_op == OP_READ) begin
        push_peak             = w_valid ? w_peak : '0;
        push_flags.peak_valid = w_valid;
      end else begin
        push_flags.index_error = 1'b1;
      end
    end else if (tick_done) begin
      push_flags.decay_changed = changed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      s1_valid   <= 1'b0;
      s1_op      <= OP_SAMPLE;
      lw_valid   <= 1'b0;
      scan_idx   <= '0;
      sweep_addr <= '0;
      changed    <= 1'b0;
    end else begin
      lw_valid <= mem_we;
      s1_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req)
              REQ_SAMPLE, REQ_READ: begin
                s1_valid <= 1'b1;
                if (!in_range) begin
                  s1_op <= OP_ERR;
                end else if (req == REQ_SAMPLE) begin
                  s1_op <= OP_SAMPLE;
                end else begin
                  s1_op <= OP_READ;
                end
              end
              REQ_TICK: begin
                state    <= ST_SCAN;
                scan_idx <= '0;
                changed  <= 1'b0;
              end
              REQ_CLEAR: begin
                state      <= ST_CLEAR;
                sweep_addr <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            s1_valid <= 1'b1;
            s1_op    <= OP_SCAN;
            scan_idx <= scan_idx + 1'b1;
          end else if (!s1_valid) begin
            state <= ST_IDLE;
          end
          if (decay_hit) begin
            changed <= 1'b1;
          end
        end
        ST_INIT, ST_CLEAR: begin
          if (sweep_active) begin
            sweep_addr <= sweep_addr + 1'b1;
            if (sweep_addr == LAST_ADDR) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= mem_raddr;
    s1_value <= bin_value;
    lw_addr  <= mem_waddr;
    lw_data  <= mem_wdata;
  end

endmodule

/* rtl/core/spectrum_peak_hold_decay_core.sv */
// Per-bin spectrum peak hold with linear decay. Each bin's state (a valid flag, the held
// peak and the latest level, all in signed 1/16 dB units) lives in one synchronous memory
// of MAX_BINS words, which is read, modified and written back, with the word written at
// the previous edge forwarded when the next item addresses the same bin. Sample and read
// items are accepted one per cycle while the result queue has room, and their result
// passes through the s1 stage and the result queue to the outputs; an index at or above
// bin_count (saturated at MAX_BINS) gives a result with only index_error set and changes
// nothing. A decay tick walks bins 0 to bin_count-1 through the single memory read port,
// one bin a cycle, and the next item waits until the walk and its last write-back are
// done; the tick gives one result with decay_changed. A clear item writes every entry
// invalid, one a cycle, and the next item waits until the sweep reaches the last entry.
// After reset the same pass runs before the first item is accepted; configuration
// writes are taken throughout. A two-entry result queue lets a new item enter while a
// finished result still waits on out_stall.
module spectrum_peak_hold_decay_core #(
  parameter int MAX_BINS   = 1024,
  parameter int LEVEL_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port: decay_step at byte address 0, bin_count at 4.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sphd_pkg::PADDR_W-1:0]        paddr,
  input  logic [sphd_pkg::PDATA_W-1:0]        pwdata,
  output logic [sphd_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // Request items.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic [sphd_pkg::BIN_INDEX_W-1:0]    bin_index,
  input  logic signed [LEVEL_BITS-1:0]        bin_value,
  // Result items.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [LEVEL_BITS-1:0]        peak_value,
  output logic                                peak_valid,
  output logic                                decay_changed,
  output logic                                index_error
);
  import sphd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_BINS);
  localparam int DATA_W = 2 * LEVEL_BITS + 1;

  cfg_t       cfg;
  q_stat_t    q_stat;
  res_flags_t push_flags;
  res_flags_t out_flags;
  logic       push;
  logic signed [LEVEL_BITS-1:0] push_peak;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  assign peak_valid    = out_flags.peak_valid;
  assign decay_changed = out_flags.decay_changed;
  assign index_error   = out_flags.index_error;

  sphd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Bin store: {valid, peak, current level} per bin.
  sphd_store #(
    .DEPTH  (MAX_BINS),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sphd_engine #(
    .MAX_BINS   (MAX_BINS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .bin_index  (bin_index),
    .bin_value  (bin_value),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_peak  (push_peak),
    .push_flags (push_flags)
  );

  sphd_outq #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_peak  (push_peak),
    .push_flags (push_flags),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .peak_value (peak_value),
    .out_flags  (out_flags),
    .q_stat     (q_stat)
  );

endmodule

/* verif/sphd_checker.sv */
`timescale 1ns / 1ps

module sphd_checker #(
  parameter int MAX_BINS   = 1024,
  parameter int LEVEL_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sphd_pkg::PADDR_W-1:0]       paddr,
  input  logic [sphd_pkg::PDATA_W-1:0]       pwdata,
  input  logic [sphd_pkg::PDATA_W-1:0]       prdata,
  input  logic                               pready,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic [sphd_pkg::BIN_INDEX_W-1:0]   bin_index,
  input  logic signed [LEVEL_BITS-1:0]       bin_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [LEVEL_BITS-1:0]       peak_value,
  input  logic                               peak_valid,
  input  logic                               decay_changed,
  input  logic                               index_error,
  output int                                 pending,
  output int                                 fail_count
);
  import sphd_pkg::*;

  localparam int LEVEL_FLOOR = -(1 << (LEVEL_BITS - 1));

  typedef struct packed {
    logic signed [LEVEL_BITS-1:0] peak;
    logic                         held;
    logic                         changed;
    logic                         range_err;
  } peak_result_t;

  // Shadow of the block's registers and per-bin state.
  logic [DECAY_STEP_W-1:0]      decay_reg;
  logic [BIN_COUNT_W-1:0]       count_reg;
  logic signed [LEVEL_BITS-1:0] peak_mem  [MAX_BINS];
  logic signed [LEVEL_BITS-1:0] level_mem [MAX_BINS];
  logic [MAX_BINS-1:0]          held_bins;

  peak_result_t expected_peaks[$];

  function automatic peak_result_t predict_peak(req_t req, logic [BIN_INDEX_W-1:0] idx,
                                                logic signed [LEVEL_BITS-1:0] lvl);
    peak_result_t res;
    int unsigned  span;
    int           lowered;
    res  = '0;
    span = (count_reg > MAX_BINS) ? MAX_BINS : count_reg;
    case (req)
      REQ_SAMPLE, REQ_READ: begin
        if (idx >= span) begin
          res.range_err = 1'b1;
        end else if (req == REQ_SAMPLE) begin
          level_mem[idx] = lvl;
          if (!held_bins[idx] || lvl > peak_mem[idx]) begin
            peak_mem[idx] = lvl;
          end
          held_bins[idx] = 1'b1;
          res.peak = peak_mem[idx];
          res.held = 1'b1;
        end else if (held_bins[idx]) begin
          res.peak = peak_mem[idx];
          res.held = 1'b1;
        end
      end
      REQ_TICK: begin
        for (int b = 0; b < span; b++) begin
          if (held_bins[b] && peak_mem[b] > level_mem[b] && decay_reg != 0) begin
            lowered = int'(peak_mem[b]) - int'(decay_reg);
            if (lowered < LEVEL_FLOOR) begin
              lowered = LEVEL_FLOOR;
            end
            if (lowered != int'(peak_mem[b])) begin
              peak_mem[b] = lowered[LEVEL_BITS-1:0];
              res.changed = 1'b1;
            end
          end
        end
      end
      default: begin
        held_bins = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    peak_result_t want;
    logic [PDATA_W-1:0] reg_val;
    if (rst) begin
      decay_reg  = DECAY_STEP_RESET;
      count_reg  = BIN_COUNT_RESET;
      held_bins  = '0;
      expected_peaks.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pready) begin
        reg_val = (paddr[PADDR_W-1:2] == REG_DECAY_STEP) ? PDATA_W'(decay_reg)
                                                          : PDATA_W'(count_reg);
        if (pwrite) begin
          if (paddr[PADDR_W-1:2] == REG_DECAY_STEP) begin
            decay_reg = pwdata[DECAY_STEP_W-1:0];
          end else begin
            count_reg = pwdata[BIN_COUNT_W-1:0];
          end
        end else if (prdata !== reg_val) begin
          $error("prdata: expected %0d, got %0d", reg_val, prdata);
          fail_count++;
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_peaks.size() == 0) begin
          $error("result with nothing outstanding: peak_value %0d", peak_value);
          fail_count++;
        end else begin
          want = expected_peaks.pop_front();
          if (peak_value !== want.peak) begin
            $error("peak_value: expected %0d, got %0d", want.peak, peak_value);
            fail_count++;
          end
          if (peak_valid !== want.held) begin
            $error("peak_valid: expected %0d, got %0d", want.held, peak_valid);
            fail_count++;
          end
          if (decay_changed !== want.changed) begin
            $error("decay_changed: expected %0d, got %0d", want.changed, decay_changed);
            fail_count++;
          end
          if (index_error !== want.range_err) begin
            $error("index_error: expected %0d, got %0d", want.range_err, index_error);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        expected_peaks.push_back(predict_peak(req_t'(req_type), bin_index, bin_value));
      end
    end
    pending = expected_peaks.size();
  end

endmodule

/* verif/tb_spectrum_peak_hold_decay_core.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the spectrum peak hold core. The checker beside the block
// predicts every result and counts mismatches; this module drives the ports and prints the verdict.
module tb_spectrum_peak_hold_decay_core;
  import sphd_pkg::*;

  localparam int MAX_BINS   = 1024;
  localparam int LEVEL_BITS = 12;
  localparam int NUM_PHASES = 8;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [PADDR_W-1:0]           paddr = '0;
  logic [PDATA_W-1:0]           pwdata = '0;
  logic [PDATA_W-1:0]           prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   req_type = REQ_SAMPLE;
  logic [BIN_INDEX_W-1:0]       bin_index = '0;
  logic signed [LEVEL_BITS-1:0] bin_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [LEVEL_BITS-1:0] peak_value;
  logic                         peak_valid;
  logic                         decay_changed;
  logic                         index_error;

  int pending;
  int fail_count;

  // When set, neither side inserts gaps, so the block runs flat out.
  bit quiet = 1'b0;
  int stall_left = 0;
  int sent_by_kind [4] = '{0, 0, 0, 0};
  int settings_used = 0;

  spectrum_peak_hold_decay_core #(
    .MAX_BINS   (MAX_BINS),
    .LEVEL_BITS (LEVEL_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .bin_index     (bin_index),
    .bin_value     (bin_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .peak_value    (peak_value),
    .peak_valid    (peak_valid),
    .decay_changed (decay_changed),
    .index_error   (index_error)
  );

  sphd_checker #(
    .MAX_BINS   (MAX_BINS),
    .LEVEL_BITS (LEVEL_BITS)
  ) peak_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .bin_index     (bin_index),
    .bin_value     (bin_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .peak_value    (peak_value),
    .peak_valid    (peak_valid),
    .decay_changed (decay_changed),
    .index_error   (index_error),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: no gap in over half the calls, else one from two random ranges, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // The result side alternates between stalled and open stretches of random length.
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end
    end
  end

  // One item on the request channel. The payload is set together with valid and held
  // until the block takes it; with no gap, valid simply stays high into the next item.
  task automatic send_req(req_t req, int idx, int lvl);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    bin_index <= idx[BIN_INDEX_W-1:0];
    bin_value <= lvl[LEVEL_BITS-1:0];
    do @(posedge clk); while (in_stall);
    sent_by_kind[req]++;
  endtask

  task automatic apb_access(bit wr, reg_idx_t which, int unsigned data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {which, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Registers change only with the block idle: the request channel is dropped and every
  // outstanding result is collected before the writes.
  // Each write is read back so the checker can compare the register contents.
  task automatic set_config(int unsigned step, int unsigned count);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    apb_access(1'b1, REG_DECAY_STEP, step);
    apb_access(1'b0, REG_DECAY_STEP, 0);
    apb_access(1'b1, REG_BIN_COUNT, count);
    apb_access(1'b0, REG_BIN_COUNT, 0);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Phases: fixed decay step and bin count pairs, taking in the extremes of both
  // registers, a count of zero and one far above the number of bins.
  int unsigned phase_step  [NUM_PHASES] = '{16, 255, 0, 1, 128, 77, 200, 3};
  int unsigned phase_count [NUM_PHASES] = '{1024, 24, 64, 2, 1, 2047, 0, 300};

  initial begin
    int unsigned used;
    int unsigned hot_base;
    int unsigned hot_size;
    int          items;
    int          roll;
    int          idx;
    int          lvl;
    req_t        req;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the register values left at reset first. Bin 1 ends up
    // well above its latest level, bin 2 sits just above the floor and bin 40 is
    // parked above the later bin count to show that shrinking the count keeps it.
    send_req(REQ_READ, 5, 0);
    send_req(REQ_SAMPLE, 0, -2048);
    send_req(REQ_SAMPLE, 1023, 2047);
    send_req(REQ_SAMPLE, 1, 100);
    send_req(REQ_SAMPLE, 1, 200);
    send_req(REQ_SAMPLE, 1, 40);
    send_req(REQ_SAMPLE, 2, -2040);
    send_req(REQ_SAMPLE, 2, -2048);
    send_req(REQ_SAMPLE, 40, 300);
    send_req(REQ_SAMPLE, 40, -300);
    send_req(REQ_TICK, 0, 0);
    send_req(REQ_READ, 1, 0);

    // Largest step: bin 1 falls below its latest level and stays there on the next
    // tick; bin 40 is now out of range and left alone.
    set_config(255, 32);
    send_req(REQ_TICK, 0, 0);
    send_req(REQ_READ, 40, 0);
    send_req(REQ_SAMPLE, 32, 500);
    send_req(REQ_READ, 31, 0);
    send_req(REQ_TICK, 0, 0);

    // No bins in use and no decay at all.
    set_config(0, 0);
    send_req(REQ_SAMPLE, 0, 1);
    send_req(REQ_TICK, 0, 0);
    send_req(REQ_READ, 0, 0);

    // A count beyond the store saturates; then a clear, and a reload after it.
    set_config(16, 2047);
    send_req(REQ_READ, 40, 0);
    send_req(REQ_READ, 1023, 0);
    send_req(REQ_CLEAR, 0, 0);
    send_req(REQ_READ, 1, 0);
    send_req(REQ_SAMPLE, 1, 7);

    // Random part. Samples cluster on a small set of hot bins so that peaks build up,
    // decay and get raised again; the rest spread over the range or fall outside it.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_config(phase_step[ph], phase_count[ph]);
      @(posedge clk);
      quiet    = (ph % 3 == 2);
      used     = (phase_count[ph] > MAX_BINS) ? MAX_BINS : phase_count[ph];
      hot_size = (used > 12) ? 12 : used;
      hot_base = (used > 12) ? $urandom_range(0, used - 12) : 0;
      items    = (used == 0) ? 30 : 150;
      for (int n = 0; n < items; n++) begin
        roll = $urandom_range(0, 999);
        if (roll < 700) begin
          req = REQ_SAMPLE;
        end else if (roll < 880) begin
          req = REQ_READ;
        end else if (roll < 980) begin
          req = REQ_TICK;
        end else begin
          req = REQ_CLEAR;
        end

        roll = $urandom_range(0, 99);
        if (used != 0 && roll < 75) begin
          idx = hot_base + $urandom_range(0, hot_size - 1);
        end else if (used != 0 && roll < 92) begin
          idx = $urandom_range(0, used - 1);
        end else begin
          idx = $urandom_range(0, 1023);
        end

        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          lvl = $urandom_range(0, 200) - 100;
        end else if (roll < 70) begin
          lvl = $urandom_range(0, 4095) - 2048;
        end else if (roll < 80) begin
          lvl = ($urandom_range(0, 1) == 1) ? 2047 - $urandom_range(0, 1)
                                             : -2048 + $urandom_range(0, 1);
        end else begin
          lvl = $urandom_range(0, 150) - 2048;
        end

        send_req(req, idx, lvl);
      end
    end

    // Drain: drop valid, collect every outstanding result and keep watching
    // for anything unexpected to show up.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Run covered %0d samples, %0d reads, %0d decay ticks and %0d clears",
             sent_by_kind[REQ_SAMPLE], sent_by_kind[REQ_READ],
             sent_by_kind[REQ_TICK], sent_by_kind[REQ_CLEAR]);
    $display("over %0d register settings, with random gaps on both channels.",
             settings_used);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, so it only fires on a hang.
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sphd_pkg.sv
rtl/core/sphd_regs.sv
rtl/core/sphd_store.sv
rtl/core/sphd_outq.sv
rtl/core/sphd_engine.sv
rtl/core/spectrum_peak_hold_decay_core.sv
verif/sphd_checker.sv
verif/tb_spectrum_peak_hold_decay_core.sv
